### sv/assert_macros.svh
// Assertion helpers used by the checker file swcct_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define SWC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define SWC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/swcct_pkg.sv
`timescale 1ns / 1ps
package swcct_pkg;

  localparam int QaW      = 34;
  localparam int HbW      = 39;
  localparam int RootW    = 39;
  localparam int RadW     = 2 * RootW;
  localparam int NumW     = 40;
  localparam int TimeW    = 32;
  localparam int OutW     = 24;
  localparam int DistRootW = 25;
  localparam int DistRadW = 2 * DistRootW;

  typedef struct packed {
    logic signed [19:0] pax;
    logic signed [19:0] pay;
    logic signed [19:0] pbx;
    logic signed [19:0] pby;
    logic signed [15:0] vax;
    logic signed [15:0] vay;
    logic signed [15:0] vbx;
    logic signed [15:0] vby;
  } geo_t;

  typedef struct packed {
    logic hit;
    logic do_div;
  } flags_t;

  typedef struct packed {
    logic                   hit;
    logic [TimeW-1:0]       t;
    logic signed [OutW-1:0] hax;
    logic signed [OutW-1:0] hay;
    logic signed [OutW-1:0] hbx;
    logic signed [OutW-1:0] hby;
  } hitpt_t;

endpackage

### sv/swcct_quad.sv
`timescale 1ns / 1ps
module swcct_quad (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_valid,
  input  swcct_pkg::geo_t                     in_geo,
  input  logic [15:0]                         in_radius_a,
  input  logic [15:0]                         in_radius_b,
  output logic                                out_valid,
  output swcct_pkg::geo_t                     out_geo,
  output logic [swcct_pkg::QaW-1:0]           out_qa,
  output logic [swcct_pkg::HbW-1:0]           out_hb,
  output logic [swcct_pkg::RadW-1:0]          out_disc,
  output logic                                out_neg
);

  localparam int Stages = 7;

  logic [Stages-1:0] v_r;
  swcct_pkg::geo_t   geo_r [Stages];

  logic signed [20:0] dpx_r, dpy_r;
  logic signed [16:0] dvx_r, dvy_r;
  logic [16:0]        rs_r;

  logic signed [33:0] dvx2_w, dvy2_w;
  logic signed [41:0] dpx2_w, dpy2_w;
  logic signed [37:0] pxvx_w, pyvy_w;
  logic [32:0]        dvx2_r, dvy2_r;
  logic [40:0]        dpx2_r, dpy2_r;
  logic [37:0]        pxvx_r, pyvy_r;
  logic [33:0]        rs2_r;

  logic [33:0] qa3_r, qa4_r, qa5_r, qa6_r;
  logic [38:0] hb3_r, hb4_r, hb5_r, hb6_r;
  logic [42:0] qc3_r;
  logic [37:0] ahb_r;
  logic [41:0] aqc_r;
  logic        qcn4_r, qcn5_r, qcn6_r;
  logic [37:0] hh_r, hl_r, ll_r, qhch_r, qhcl_r, qlch_r, qlcl_r;
  logic [75:0] sq_r, pq_r;
  logic [77:0] disc_r;
  logic        neg_r;
  logic [33:0] qa7_r;
  logic [38:0] hb7_r;

  assign dvx2_w = dvx_r * dvx_r;
  assign dvy2_w = dvy_r * dvy_r;
  assign dpx2_w = dpx_r * dpx_r;
  assign dpy2_w = dpy_r * dpy_r;
  assign pxvx_w = dpx_r * dvx_r;
  assign pyvy_w = dpy_r * dvy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[Stages-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo_r[0] <= in_geo;
      for (int k = 1; k < Stages; k++) begin
        geo_r[k] <= geo_r[k-1];
      end
      dpx_r <= $signed({in_geo.pax[19], in_geo.pax}) - $signed({in_geo.pbx[19], in_geo.pbx});
      dpy_r <= $signed({in_geo.pay[19], in_geo.pay}) - $signed({in_geo.pby[19], in_geo.pby});
      dvx_r <= $signed({in_geo.vax[15], in_geo.vax}) - $signed({in_geo.vbx[15], in_geo.vbx});
      dvy_r <= $signed({in_geo.vay[15], in_geo.vay}) - $signed({in_geo.vby[15], in_geo.vby});
      rs_r  <= {1'b0, in_radius_a} + {1'b0, in_radius_b};

      dvx2_r <= dvx2_w[32:0];
      dvy2_r <= dvy2_w[32:0];
      dpx2_r <= dpx2_w[40:0];
      dpy2_r <= dpy2_w[40:0];
      pxvx_r <= pxvx_w;
      pyvy_r <= pyvy_w;
      rs2_r  <= rs_r * rs_r;

      qa3_r <= {1'b0, dvx2_r} + {1'b0, dvy2_r};
      hb3_r <= {pxvx_r[37], pxvx_r} + {pyvy_r[37], pyvy_r};
      qc3_r <= {2'b0, dpx2_r} + {2'b0, dpy2_r} - {9'b0, rs2_r};

      ahb_r  <= hb3_r[38] ? 38'(-hb3_r) : hb3_r[37:0];
      aqc_r  <= qc3_r[42] ? 42'(-qc3_r) : qc3_r[41:0];
      qcn4_r <= qc3_r[42];
      qa4_r  <= qa3_r;
      hb4_r  <= hb3_r;

      hh_r   <= ahb_r[37:19] * ahb_r[37:19];
      hl_r   <= ahb_r[37:19] * ahb_r[18:0];
      ll_r   <= ahb_r[18:0] * ahb_r[18:0];
      qhch_r <= qa4_r[33:17] * aqc_r[41:21];
      qhcl_r <= qa4_r[33:17] * aqc_r[20:0];
      qlch_r <= qa4_r[16:0] * aqc_r[41:21];
      qlcl_r <= qa4_r[16:0] * aqc_r[20:0];
      qcn5_r <= qcn4_r;
      qa5_r  <= qa4_r;
      hb5_r  <= hb4_r;

      sq_r   <= {hh_r, 38'b0} + {18'b0, hl_r, 20'b0} + {38'b0, ll_r};
      pq_r   <= {qhch_r, 38'b0} + {21'b0, qhcl_r, 17'b0} + {17'b0, qlch_r, 21'b0}
                + {38'b0, qlcl_r};
      qcn6_r <= qcn5_r;
      qa6_r  <= qa5_r;
      hb6_r  <= hb5_r;

      if (qcn6_r) begin
        disc_r <= {2'b0, sq_r} + {2'b0, pq_r};
        neg_r  <= 1'b0;
      end else begin
        disc_r <= {2'b0, sq_r - pq_r};
        neg_r  <= pq_r > sq_r;
      end
      qa7_r <= qa6_r;
      hb7_r <= hb6_r;
    end
  end

  assign out_valid = v_r[Stages-1];
  assign out_geo   = geo_r[Stages-1];
  assign out_qa    = qa7_r;
  assign out_hb    = hb7_r;
  assign out_disc  = disc_r;
  assign out_neg   = neg_r;

endmodule

### sv/swcct_root.sv
`timescale 1ns / 1ps
module swcct_root (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_valid,
  input  swcct_pkg::geo_t                   in_geo,
  input  logic [swcct_pkg::QaW-1:0]         in_qa,
  input  logic [swcct_pkg::HbW-1:0]         in_hb,
  input  logic [swcct_pkg::RadW-1:0]        in_disc,
  input  logic                              in_neg,
  output logic                              out_valid,
  output swcct_pkg::geo_t                   out_geo,
  output logic [swcct_pkg::QaW-1:0]         out_qa,
  output logic [swcct_pkg::NumW-1:0]        out_num,
  output swcct_pkg::flags_t                 out_flags
);

  localparam int N    = swcct_pkg::RootW;
  localparam int RadW = swcct_pkg::RadW;
  localparam int HbW  = swcct_pkg::HbW;

  logic [N-1:0]              v_r;
  logic [RadW-1:0]           rad_r  [N];
  logic [N+1:0]              rem_r  [N];
  logic [N-1:0]              root_r [N];
  swcct_pkg::geo_t           geo_r  [N];
  logic [swcct_pkg::QaW-1:0] qa_r   [N];
  logic [HbW-1:0]            hb_r   [N];
  logic [N-1:0]              neg_r;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [RadW-1:0] rad_p;
    logic [N+1:0]    rem_p;
    logic [N+1:0]    rem_sh;
    logic [N+1:0]    trial;
    logic [N-1:0]    root_p;
    logic            ge;
    if (k == 0) begin : g_head
      assign rad_p  = in_disc;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_tail
      assign rad_p  = rad_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
    end
    assign rem_sh = {rem_p[N-1:0], rad_p[RadW-1 -: 2]};
    assign trial  = {root_p, 2'b01};
    assign ge     = rem_sh >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[k]  <= rad_p << 2;
        rem_r[k]  <= ge ? rem_sh - trial : rem_sh;
        root_r[k] <= {root_p[N-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo_r[0] <= in_geo;
      qa_r[0]  <= in_qa;
      hb_r[0]  <= in_hb;
      for (int k = 1; k < N; k++) begin
        geo_r[k] <= geo_r[k-1];
        qa_r[k]  <= qa_r[k-1];
        hb_r[k]  <= hb_r[k-1];
      end
      neg_r <= {neg_r[N-2:0], in_neg};
    end
  end

  logic [HbW+1:0]             nhb, n1, n0, kept;
  logic [swcct_pkg::NumW-1:0] num_nxt;
  swcct_pkg::flags_t          flags_nxt;
  logic                       v_out_r;
  swcct_pkg::geo_t            geo_out_r;
  logic [swcct_pkg::QaW-1:0]  qa_out_r;
  logic [swcct_pkg::NumW-1:0] num_r;
  swcct_pkg::flags_t          flags_r;

  always_comb begin
    nhb  = (HbW+2)'(0) - {{2{hb_r[N-1][HbW-1]}}, hb_r[N-1]};
    n1   = nhb - {2'b0, root_r[N-1]};
    n0   = nhb + {2'b0, root_r[N-1]};
    kept = n1[HbW+1] ? n0 : n1;
    priority if (qa_r[N-1] == '0) begin
      flags_nxt = '{hit: 1'b0, do_div: 1'b0};
      num_nxt   = '0;
    end else if (neg_r[N-1]) begin
      flags_nxt = '{hit: 1'b0, do_div: hb_r[N-1][HbW-1]};
      num_nxt   = nhb[swcct_pkg::NumW-1:0];
    end else begin
      flags_nxt = '{hit: !kept[HbW+1], do_div: !kept[HbW+1]};
      num_nxt   = kept[swcct_pkg::NumW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      v_out_r <= 1'b0;
    end else if (adv) begin
      v_r     <= {v_r[N-2:0], in_valid};
      v_out_r <= v_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo_out_r <= geo_r[N-1];
      qa_out_r  <= qa_r[N-1];
      num_r     <= num_nxt;
      flags_r   <= flags_nxt;
    end
  end

  assign out_valid = v_out_r;
  assign out_geo   = geo_out_r;
  assign out_qa    = qa_out_r;
  assign out_num   = num_r;
  assign out_flags = flags_r;

endmodule

### sv/swcct_div.sv
`timescale 1ns / 1ps
module swcct_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_valid,
  input  swcct_pkg::geo_t                   in_geo,
  input  logic [swcct_pkg::QaW-1:0]         in_qa,
  input  logic [swcct_pkg::NumW-1:0]        in_num,
  input  swcct_pkg::flags_t                 in_flags,
  output logic                              out_valid,
  output swcct_pkg::geo_t                   out_geo,
  output logic                              out_hit,
  output logic [swcct_pkg::TimeW-1:0]       out_time
);

  localparam int Q   = swcct_pkg::TimeW;
  localparam int QaW = swcct_pkg::QaW;
  localparam int RW  = QaW + 1;

  logic                 v0_r;
  logic [RW-1:0]        r0_r;
  logic [Q-1:0]         low0_r;
  logic                 sat0_r;
  logic [QaW-1:0]       qa0_r;
  swcct_pkg::geo_t      geo0_r;
  swcct_pkg::flags_t    flags0_r;

  logic [Q-1:0]         v_r;
  logic [RW-1:0]        r_r    [Q];
  logic [Q-1:0]         low_r  [Q];
  logic [Q-1:0]         q_r    [Q];
  logic [QaW-1:0]       qa_r   [Q];
  swcct_pkg::geo_t      geo_r  [Q];
  swcct_pkg::flags_t    flags_r[Q];
  logic [Q-1:0]         sat_r;

  logic                 vf_r;
  swcct_pkg::geo_t      geof_r;
  logic                 hitf_r;
  logic [Q-1:0]         timef_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      r0_r     <= {{(RW-24){1'b0}}, in_num[39:16]};
      low0_r   <= {in_num[15:0], 16'b0};
      sat0_r   <= {10'b0, in_num} >= {in_qa, 16'b0};
      qa0_r    <= in_qa;
      geo0_r   <= in_geo;
      flags0_r <= in_flags;
    end
  end

  for (genvar k = 0; k < Q; k++) begin : g_step
    logic [RW-1:0]  r_p;
    logic [RW-1:0]  r_sh;
    logic [Q-1:0]   low_p;
    logic [Q-1:0]   q_p;
    logic [QaW-1:0] qa_p;
    logic           ge;
    if (k == 0) begin : g_head
      assign r_p   = r0_r;
      assign low_p = low0_r;
      assign q_p   = '0;
      assign qa_p  = qa0_r;
    end else begin : g_tail
      assign r_p   = r_r[k-1];
      assign low_p = low_r[k-1];
      assign q_p   = q_r[k-1];
      assign qa_p  = qa_r[k-1];
    end
    assign r_sh = {r_p[RW-2:0], low_p[Q-1]};
    assign ge   = r_sh >= {1'b0, qa_p};
    always_ff @(posedge clk) begin
      if (adv) begin
        r_r[k]   <= ge ? r_sh - {1'b0, qa_p} : r_sh;
        low_r[k] <= low_p << 1;
        q_r[k]   <= {q_p[Q-2:0], ge};
        qa_r[k]  <= qa_p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo_r[0]   <= geo0_r;
      flags_r[0] <= flags0_r;
      for (int k = 1; k < Q; k++) begin
        geo_r[k]   <= geo_r[k-1];
        flags_r[k] <= flags_r[k-1];
      end
      sat_r <= {sat_r[Q-2:0], sat0_r};

      geof_r  <= geo_r[Q-1];
      hitf_r  <= flags_r[Q-1].hit;
      if (!flags_r[Q-1].do_div) begin
        timef_r <= '0;
      end else if (sat_r[Q-1]) begin
        timef_r <= '1;
      end else begin
        timef_r <= q_r[Q-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v_r  <= '0;
      vf_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
      v_r  <= {v_r[Q-2:0], v0_r};
      vf_r <= v_r[Q-1];
    end
  end

  assign out_valid = vf_r;
  assign out_geo   = geof_r;
  assign out_hit   = hitf_r;
  assign out_time  = timef_r;

endmodule

### sv/swcct_place.sv
`timescale 1ns / 1ps
module swcct_place (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_valid,
  input  swcct_pkg::geo_t                     in_geo,
  input  logic                                in_hit,
  input  logic [swcct_pkg::TimeW-1:0]         in_time,
  output logic                                out_valid,
  output swcct_pkg::hitpt_t                   out_pt,
  output logic [swcct_pkg::DistRootW-1:0]     out_root
);

  localparam int N    = swcct_pkg::DistRootW;
  localparam int RadW = swcct_pkg::DistRadW;
  localparam int OW   = swcct_pkg::OutW;
  localparam int Pre  = 5;

  logic [Pre-1:0] pv_r;

  logic signed [48:0] pax_w, pay_w, pbx_w, pby_w;
  logic signed [48:0] pax_r, pay_r, pbx_r, pby_r;
  swcct_pkg::geo_t    geoa_r;
  logic               hita_r;
  logic [31:0]        ta_r;

  swcct_pkg::hitpt_t  ptb_r, ptc_r, ptd_r, pte_r;
  logic [24:0]        ex_r, ey_r;
  logic signed [49:0] ex2_w, ey2_w;
  logic [48:0]        ex2_r, ey2_r;
  logic [RadW-1:0]    dsq_r;

  function automatic logic [OW-1:0] place_sat(input logic [19:0] pos, input logic [32:0] dlt);
    logic [33:0] sum;
    sum = {{14{pos[19]}}, pos} + {dlt[32], dlt};
    if (sum[33:OW-1] == '0 || sum[33:OW-1] == '1) begin
      place_sat = sum[OW-1:0];
    end else begin
      place_sat = sum[33] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    end
  endfunction

  assign pax_w = $signed(in_geo.vax) * $signed({1'b0, in_time});
  assign pay_w = $signed(in_geo.vay) * $signed({1'b0, in_time});
  assign pbx_w = $signed(in_geo.vbx) * $signed({1'b0, in_time});
  assign pby_w = $signed(in_geo.vby) * $signed({1'b0, in_time});
  assign ex2_w = $signed(ex_r) * $signed(ex_r);
  assign ey2_w = $signed(ey_r) * $signed(ey_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      pax_r  <= pax_w;
      pay_r  <= pay_w;
      pbx_r  <= pbx_w;
      pby_r  <= pby_w;
      geoa_r <= in_geo;
      hita_r <= in_hit;
      ta_r   <= in_time;

      ptb_r.hit <= hita_r;
      ptb_r.t   <= ta_r;
      ptb_r.hax <= place_sat(geoa_r.pax, pax_r[48:16]);
      ptb_r.hay <= place_sat(geoa_r.pay, pay_r[48:16]);
      ptb_r.hbx <= place_sat(geoa_r.pbx, pbx_r[48:16]);
      ptb_r.hby <= place_sat(geoa_r.pby, pby_r[48:16]);

      ptc_r <= ptb_r;
      ex_r  <= {ptb_r.hax[OW-1], ptb_r.hax} - {ptb_r.hbx[OW-1], ptb_r.hbx};
      ey_r  <= {ptb_r.hay[OW-1], ptb_r.hay} - {ptb_r.hby[OW-1], ptb_r.hby};

      ptd_r <= ptc_r;
      ex2_r <= ex2_w[48:0];
      ey2_r <= ey2_w[48:0];

      pte_r <= ptd_r;
      dsq_r <= {1'b0, ex2_r} + {1'b0, ey2_r};
    end
  end

  logic [N-1:0]      v_r;
  logic [RadW-1:0]   rad_r  [N];
  logic [N+1:0]      rem_r  [N];
  logic [N-1:0]      root_r [N];
  swcct_pkg::hitpt_t pt_r   [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [RadW-1:0] rad_p;
    logic [N+1:0]    rem_p;
    logic [N+1:0]    rem_sh;
    logic [N+1:0]    trial;
    logic [N-1:0]    root_p;
    logic            ge;
    if (k == 0) begin : g_head
      assign rad_p  = dsq_r;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_tail
      assign rad_p  = rad_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
    end
    assign rem_sh = {rem_p[N-1:0], rad_p[RadW-1 -: 2]};
    assign trial  = {root_p, 2'b01};
    assign ge     = rem_sh >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[k]  <= rad_p << 2;
        rem_r[k]  <= ge ? rem_sh - trial : rem_sh;
        root_r[k] <= {root_p[N-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt_r[0] <= pte_r;
      for (int k = 1; k < N; k++) begin
        pt_r[k] <= pt_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
      v_r  <= '0;
    end else if (adv) begin
      pv_r <= {pv_r[Pre-2:0], in_valid};
      v_r  <= {v_r[N-2:0], pv_r[Pre-1]};
    end
  end

  assign out_valid = v_r[N-1];
  assign out_pt    = pt_r[N-1];
  assign out_root  = root_r[N-1];

endmodule

### sv/swept_circle_collision_time_core.sv
`timescale 1ns / 1ps
// Channel   Handshake           Payload
// in_       in_valid/in_stall   two circles: positions, velocities, radii
// out_      out_valid/out_stall hit flag, time, hit positions, distance
//
// One transaction enters per cycle while in_stall is low; it passes the
// 39-step discriminant square root, the 32-step time divider and the
// 25-step distance square root, each one digit per register stage.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// out_stall on a full output register freezes the whole pipeline and is
// seen on in_stall in the same cycle.
module swept_circle_collision_time_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [19:0] in_pos_a_x,
  input  logic signed [19:0] in_pos_a_y,
  input  logic signed [19:0] in_pos_b_x,
  input  logic signed [19:0] in_pos_b_y,
  input  logic signed [15:0] in_vel_a_x,
  input  logic signed [15:0] in_vel_a_y,
  input  logic signed [15:0] in_vel_b_x,
  input  logic signed [15:0] in_vel_b_y,
  input  logic [15:0]        in_radius_a,
  input  logic [15:0]        in_radius_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [31:0]        out_hit_time,
  output logic signed [23:0] out_hit_a_x,
  output logic signed [23:0] out_hit_a_y,
  output logic signed [23:0] out_hit_b_x,
  output logic signed [23:0] out_hit_b_y,
  output logic [23:0]        out_hit_distance
);

  logic adv;
  swcct_pkg::geo_t in_geo;

  logic                            q_valid;
  swcct_pkg::geo_t                 q_geo;
  logic [swcct_pkg::QaW-1:0]       q_qa;
  logic [swcct_pkg::HbW-1:0]       q_hb;
  logic [swcct_pkg::RadW-1:0]      q_disc;
  logic                            q_neg;

  logic                            r_valid;
  swcct_pkg::geo_t                 r_geo;
  logic [swcct_pkg::QaW-1:0]       r_qa;
  logic [swcct_pkg::NumW-1:0]      r_num;
  swcct_pkg::flags_t               r_flags;

  logic                            d_valid;
  swcct_pkg::geo_t                 d_geo;
  logic                            d_hit;
  logic [swcct_pkg::TimeW-1:0]     d_time;

  logic                            p_valid;
  swcct_pkg::hitpt_t               p_pt;
  logic [swcct_pkg::DistRootW-1:0] p_root;

  logic        out_valid_r;
  logic        out_hit_r;
  logic [31:0] out_time_r;
  logic [23:0] out_ax_r, out_ay_r, out_bx_r, out_by_r, out_dist_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  assign in_geo = '{pax: in_pos_a_x, pay: in_pos_a_y, pbx: in_pos_b_x, pby: in_pos_b_y,
                    vax: in_vel_a_x, vay: in_vel_a_y, vbx: in_vel_b_x, vby: in_vel_b_y};

  swcct_quad u_quad (
    .clk, .rst_n, .adv,
    .in_valid, .in_geo, .in_radius_a, .in_radius_b,
    .out_valid(q_valid), .out_geo(q_geo), .out_qa(q_qa), .out_hb(q_hb),
    .out_disc(q_disc), .out_neg(q_neg)
  );

  swcct_root u_root (
    .clk, .rst_n, .adv,
    .in_valid(q_valid), .in_geo(q_geo), .in_qa(q_qa), .in_hb(q_hb),
    .in_disc(q_disc), .in_neg(q_neg),
    .out_valid(r_valid), .out_geo(r_geo), .out_qa(r_qa), .out_num(r_num),
    .out_flags(r_flags)
  );

  swcct_div u_div (
    .clk, .rst_n, .adv,
    .in_valid(r_valid), .in_geo(r_geo), .in_qa(r_qa), .in_num(r_num),
    .in_flags(r_flags),
    .out_valid(d_valid), .out_geo(d_geo), .out_hit(d_hit), .out_time(d_time)
  );

  swcct_place u_place (
    .clk, .rst_n, .adv,
    .in_valid(d_valid), .in_geo(d_geo), .in_hit(d_hit), .in_time(d_time),
    .out_valid(p_valid), .out_pt(p_pt), .out_root(p_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r  <= p_pt.hit;
      out_time_r <= p_pt.t;
      if (p_pt.hit) begin
        out_ax_r   <= p_pt.hax;
        out_ay_r   <= p_pt.hay;
        out_bx_r   <= p_pt.hbx;
        out_by_r   <= p_pt.hby;
        out_dist_r <= p_root[swcct_pkg::DistRootW-1] ? '1 : p_root[23:0];
      end else begin
        out_ax_r   <= '0;
        out_ay_r   <= '0;
        out_bx_r   <= '0;
        out_by_r   <= '0;
        out_dist_r <= '1;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_hit_time     = out_time_r;
  assign out_hit_a_x      = out_ax_r;
  assign out_hit_a_y      = out_ay_r;
  assign out_hit_b_x      = out_bx_r;
  assign out_hit_b_y      = out_by_r;
  assign out_hit_distance = out_dist_r;

endmodule

### sv/swcct_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module swcct_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit,
  input logic [31:0] out_hit_time,
  input logic [23:0] out_hit_a_x,
  input logic [23:0] out_hit_a_y,
  input logic [23:0] out_hit_b_x,
  input logic [23:0] out_hit_b_y,
  input logic [23:0] out_hit_distance
);

  logic         miss_clear;
  logic [152:0] payload_w;

  assign miss_clear = out_hit_a_x == 24'd0 && out_hit_a_y == 24'd0 && out_hit_b_x == 24'd0 &&
                      out_hit_b_y == 24'd0 && out_hit_distance == 24'hFFFFFF;
  assign payload_w  = {out_hit, out_hit_time, out_hit_a_x, out_hit_a_y, out_hit_b_x,
                       out_hit_b_y, out_hit_distance};

  `SWC_ASSERT_NOW(a_miss_fill, out_valid && !out_hit, miss_clear, "miss carries hit data")
  `SWC_ASSERT_NOW(a_back_stall, out_valid && out_stall, in_stall, "input taken while held")
  `SWC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "held transaction dropped")
  `SWC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(payload_w), "held data moved")

endmodule

bind swept_circle_collision_time_core swcct_checker u_swcct_checker (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_hit,
  .out_hit_time, .out_hit_a_x, .out_hit_a_y, .out_hit_b_x, .out_hit_b_y,
  .out_hit_distance
);
